// ===== design/bei_pkg.sv =====
// Package for the breakpoint envelope interpolator: request/response words,
// breakpoint storage entry, region and request codes, fixed-point constants.
// No dependencies.
package bei_pkg;

	localparam int POS_W   = 32;
	localparam int LVL_W   = 16;
	localparam int LERP_W  = 16;
	localparam int COUNT_W = 5;
	localparam int SLOT_W  = 4;
	localparam int REGION_W = 3;

	localparam logic [LVL_W-1:0] ONE_Q15 = 16'd32768;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EVAL  = 1'b1;

	localparam logic [REGION_W-1:0] REGION_EMPTY  = 3'd0;
	localparam logic [REGION_W-1:0] REGION_BEFORE = 3'd1;
	localparam logic [REGION_W-1:0] REGION_AFTER  = 3'd2;
	localparam logic [REGION_W-1:0] REGION_INTERP = 3'd3;
	localparam logic [REGION_W-1:0] REGION_NONE   = 3'd4;

	typedef struct packed {
		logic              req_type;
		logic [SLOT_W-1:0] point_index;
		logic [POS_W-1:0]  point_x;
		logic [LVL_W-1:0]  point_y;
		logic [POS_W-1:0]  time_x;
	} req_word_t;

	typedef struct packed {
		logic [LVL_W-1:0]    level_out;
		logic [REGION_W-1:0] region;
	} rsp_word_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [LVL_W-1:0] lvl;
	} point_t;

	// Divider handshake between the sequencer and the divider
	typedef struct packed {
		logic             start;
		logic [POS_W-1:0] num;
		logic [POS_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [LERP_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== design/bei_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Computes floor((num << LERP_W) / den) for num < den. Depends on bei_pkg.
module bei_divider
	import bei_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(LERP_W);

	logic [POS_W-1:0]  rem_q;
	logic [POS_W-1:0]  den_q;
	logic [LERP_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [POS_W:0]    shifted;
	logic [POS_W:0]    diff;
	logic              fits;

	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(LERP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[POS_W-1:0] : shifted[POS_W-1:0];
			quot_q <= {quot_q[LERP_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ===== design/breakpoint_envelope_interpolator_core.sv =====
// Breakpoint envelope interpolator core: breakpoint table, scan sequencer, divider, blend.
// Depends on bei_pkg and bei_divider.
// A write word never occupies the sequencer; an evaluate result loads from the emit state, reached
// after accept (empty table) or after end checks, segment scan, 16-step divide, multiply, add.
// One word at a time: the next word is taken the cycle after the result loads, so an evaluate
// holds the input through its scan and divide and through any output stall.
// Reset (arst_n low, asynchronous): point count 0, sequencer idle, no response pending.
module breakpoint_envelope_interpolator_core
	import bei_pkg::*;
#(
	parameter int MAX_POINTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_word_t          req_word,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_word_t          rsp_word,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = ($clog2(MAX_POINTS + 1) > COUNT_W) ? $clog2(MAX_POINTS + 1) : COUNT_W;

	// Sequencer state codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FIRST = 3'd1;
	localparam logic [2:0] ST_LAST  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_ADD   = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	logic [2:0]           state_q;
	logic [COUNT_W-1:0]   point_count_q;
	logic [CNT_W-1:0]     n_q;
	logic [IDX_W-1:0]     idx_q;
	logic [POS_W-1:0]     tx_q;
	logic [POS_W-1:0]     prev_x_q;
	logic [LVL_W-1:0]     prev_y_q;
	logic [LVL_W-1:0]     y0_q;
	logic [LVL_W-1:0]     y1_q;
	logic signed [2*LERP_W+1:0] prod_q;
	logic [LVL_W-1:0]     res_level_q;
	logic [REGION_W-1:0]  res_region_q;
	logic                 rsp_valid_q;
	rsp_word_t            rsp_word_q;

	// Breakpoint table: one write port, one registered read port
	point_t               table_mem [MAX_POINTS];
	point_t               rd_q;
	logic [IDX_W-1:0]     rd_addr;

	logic                 req_fire;
	logic                 rsp_free;
	logic [CNT_W-1:0]     n_next;
	logic [CNT_W-1:0]     n_last;
	logic                 seg_hit;
	logic [LVL_W-1:0]     clamped_y;
	logic signed [LVL_W:0] y_delta;
	logic signed [LVL_W+1:0] interp;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	assign req_stall = (state_q != ST_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// Clamp the programmed count to the table depth
	assign n_next = (CNT_W'(point_count_q) > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
		: CNT_W'(point_count_q);
	assign n_last = n_q - 1'b1;

	assign clamped_y = (req_word.point_y > ONE_Q15) ? ONE_Q15 : req_word.point_y;

	// Current segment is [prev, rd_q)
	assign seg_hit = (tx_q >= prev_x_q) && (tx_q < rd_q.pos);

	// Next table address: entry 0 on accept, last entry after the first check,
	// then walk upward one entry per cycle
	always_comb begin
		case (state_q)
			ST_IDLE:  rd_addr = '0;
			ST_FIRST: rd_addr = n_last[IDX_W-1:0];
			ST_LAST:  rd_addr = IDX_W'(1);
			ST_SCAN:  rd_addr = idx_q + 1'b1;
			default:  rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_fire && req_word.req_type == REQ_WRITE
			&& CNT_W'(req_word.point_index) < CNT_W'(MAX_POINTS)) begin
			table_mem[IDX_W'(req_word.point_index)] <= '{pos: req_word.point_x, lvl: clamped_y};
		end
		rd_q <= table_mem[rd_addr];
	end

	// Start the divide on the matching segment: (tx - x_i) << 16 / (x_i+1 - x_i)
	assign div_req.start = (state_q == ST_SCAN) && seg_hit;
	assign div_req.num   = tx_q - prev_x_q;
	assign div_req.den   = rd_q.pos - prev_x_q;

	bei_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Blend as y0 + floor(lerp * (y1 - y0) / 65536); equals the two-product form
	assign y_delta = $signed({1'b0, y1_q}) - $signed({1'b0, y0_q});
	assign interp  = $signed({2'b00, y0_q}) + prod_q[2*LERP_W+1:LERP_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_count_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				point_count_q <= cfg_data;
			end
			// Load the output register from the emit state, drop the word once it is taken
			if (state_q == ST_EMIT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire && req_word.req_type == REQ_EVAL) begin
						state_q <= (n_next == '0) ? ST_EMIT : ST_FIRST;
					end
				end
				ST_FIRST: begin
					state_q <= (tx_q <= rd_q.pos) ? ST_EMIT : ST_LAST;
				end
				ST_LAST: begin
					state_q <= (tx_q >= rd_q.pos) ? ST_EMIT : ST_SCAN;
				end
				ST_SCAN: begin
					if (seg_hit) begin
						state_q <= ST_DIV;
					end else if (CNT_W'(idx_q) == n_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// Hold the result until the output register frees up
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				tx_q         <= req_word.time_x;
				n_q          <= n_next;
				res_level_q  <= '0;
				res_region_q <= REGION_EMPTY;
			end
			ST_FIRST: begin
				prev_x_q     <= rd_q.pos;
				prev_y_q     <= rd_q.lvl;
				res_level_q  <= ONE_Q15 - rd_q.lvl;
				res_region_q <= REGION_BEFORE;
			end
			ST_LAST: begin
				idx_q        <= IDX_W'(1);
				res_level_q  <= ONE_Q15 - rd_q.lvl;
				res_region_q <= REGION_AFTER;
			end
			ST_SCAN: begin
				if (seg_hit) begin
					y0_q <= prev_y_q;
					y1_q <= rd_q.lvl;
				end else begin
					// Advance: this entry becomes the left edge of the next segment
					prev_x_q     <= rd_q.pos;
					prev_y_q     <= rd_q.lvl;
					idx_q        <= idx_q + 1'b1;
					res_level_q  <= '0;
					res_region_q <= REGION_NONE;
				end
			end
			ST_MUL: begin
				prod_q <= $signed({1'b0, div_rsp.quot}) * y_delta;
			end
			ST_ADD: begin
				res_level_q  <= ONE_Q15 - interp[LVL_W-1:0];
				res_region_q <= REGION_INTERP;
			end
			ST_EMIT: begin
				if (rsp_free) begin
					rsp_word_q.level_out <= res_level_q;
					rsp_word_q.region    <= res_region_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

`ifndef SYNTHESIS
	// A write word never occupies the sequencer
	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_word.req_type == REQ_WRITE |=> !req_stall)
		else $error("write word kept the sequencer busy");

	// Empty table and unmatched scan both report a zero level
	a_zero_regions: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_word.region == REGION_EMPTY || rsp_word.region == REGION_NONE)
		|-> rsp_word.level_out == '0)
		else $error("nonzero level for empty or unmatched region");

	// Level stays within Q1.15 unity and the region is a defined code
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_word.level_out <= ONE_Q15 && rsp_word.region <= REGION_NONE)
		else $error("response out of range");

	// Divider finishes only while the sequencer waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider done outside divide phase");
`endif

endmodule
